[rtl/mrp_pd_attitude_torque_defines.svh]
// assertion helpers, sampled on clk and quiet while rst_n is low
`ifndef MRP_PD_ATTITUDE_TORQUE_DEFINES_SVH
`define MRP_PD_ATTITUDE_TORQUE_DEFINES_SVH

// same-cycle implication
`define MRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mrp_pkg.sv]
package mrp_pkg;

  localparam int FIELD_W      = 21;
  localparam int INERTIA_FRAC = 8;
  localparam int TORQUE_FRAC  = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 63;
  localparam int PIPE_LAT     = 7;

  typedef logic signed [31:0]         q_t;
  typedef logic signed [FIELD_W-1:0]  fld_t;
  typedef logic signed [66:0]         wide_t;
  typedef logic [CFG_DATA_W-1:0]      pack63_t;
  typedef q_t                         vec3_t [3];
  typedef fld_t                       mat3_t [3][3];

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_K        = 3'd0,
    CFG_GAIN_P        = 3'd1,
    CFG_INERTIA_X     = 3'd2,
    CFG_INERTIA_Y     = 3'd3,
    CFG_INERTIA_Z     = 3'd4,
    CFG_KNOWN_TORQUE  = 3'd5
  } cfg_idx_t;

  localparam wide_t Q_MAX = 67'sd2147483647;
  localparam wide_t Q_MIN = -67'sd2147483648;

  function automatic q_t sat32(wide_t x);
    q_t res;
    if (x > Q_MAX) begin
      res = 32'sh7fffffff;
    end else if (x < Q_MIN) begin
      res = 32'sh80000000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

  function automatic fld_t field21(pack63_t r, int j);
    fld_t f;
    f = r[j*FIELD_W +: FIELD_W];
    return f;
  endfunction

endpackage

[rtl/mrp_pd_attitude_torque.sv]
// mrp pd attitude control law, fully pipelined
// input channel: a guidance sample (sigma, rate error, reference rate,
//   reference acceleration, signed fixed point with FRAC_BITS fraction
//   bits) transfers on a clock edge with start high and busy low
// busy is high only in the cycle after a reset edge; otherwise a new
//   sample is taken every cycle, one transfer per clock
// result channel: out_valid is high for one cycle with the torque
//   triple on out_torque_*; the receiver takes it in that cycle and
//   cannot hold it off, so the pipeline never stalls
// throughput: one sample per cycle; the pipeline depth is set by the
//   chain of two dependent matrix-vector and cross-product units
//   (2 stages each), the difference stage between them, the input
//   stage and the output sum
// configuration: gains, inertia rows and known torque are written on
//   cfg_we with cfg_index and cfg_data, only while no sample is in
//   flight (the user's rule, not enforced); unmapped indices are dropped
// reset: synchronous, clears the valid pipeline and all config registers
`include "mrp_pd_attitude_torque_defines.svh"

module mrp_pd_attitude_torque #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration port
  input  logic                                cfg_we,
  input  logic [mrp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mrp_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [31:0]                  in_sigma_x,
  input  logic signed [31:0]                  in_sigma_y,
  input  logic signed [31:0]                  in_sigma_z,
  input  logic signed [31:0]                  in_rate_err_x,
  input  logic signed [31:0]                  in_rate_err_y,
  input  logic signed [31:0]                  in_rate_err_z,
  input  logic signed [31:0]                  in_ref_rate_x,
  input  logic signed [31:0]                  in_ref_rate_y,
  input  logic signed [31:0]                  in_ref_rate_z,
  input  logic signed [31:0]                  in_ref_accel_x,
  input  logic signed [31:0]                  in_ref_accel_y,
  input  logic signed [31:0]                  in_ref_accel_z,
  // result channel
  output logic                                out_valid,
  output logic signed [31:0]                  out_torque_x,
  output logic signed [31:0]                  out_torque_y,
  output logic signed [31:0]                  out_torque_z
);
  import mrp_pkg::*;

  // rounded gain product width
  localparam int GP_W = 65;
  localparam int GR_W = GP_W - FRAC_BITS;
  localparam int GS_W = GR_W + 1;

  // config registers
  logic [31:0] gain_k_r;
  logic [31:0] gain_p_r;
  pack63_t     inertia_row_x_r;
  pack63_t     inertia_row_y_r;
  pack63_t     inertia_row_z_r;
  pack63_t     known_torque_r;

  logic                in_acc;
  logic                busy_r;
  logic [PIPE_LAT-1:0] vld_r;

  mat3_t inertia;

  // stage 1: body rate, captured inputs
  vec3_t w_r, wr1_r, dwr1_r, sig1_r, rerr1_r;
  // stage 2
  vec3_t wr2_r, dwr2_r;
  logic signed [GR_W-1:0] kterm_r [3];
  logic signed [GR_W-1:0] pterm_r [3];
  // stage 3
  vec3_t iw, wxr, wr3_r, dwr3_r;
  logic signed [GS_W-1:0] gsum3_r [3];
  // stage 4
  vec3_t d_r, iw4_r, wr4_r;
  logic signed [GS_W-1:0] gsum4_r [3];
  // stage 5 / 6
  logic signed [GS_W-1:0] gsum5_r [3];
  logic signed [GS_W-1:0] gsum6_r [3];
  vec3_t t3, t4;
  // stage 7
  q_t    tq_r [3];

  vec3_t in_sig, in_rerr, in_wr, in_dwr;
  logic signed [GP_W-1:0] kprod [3];
  logic signed [GP_W-1:0] pprod [3];
  wide_t lt [3];

  assign in_acc = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[PIPE_LAT-2:0], in_acc};
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_k_r        <= '0;
      gain_p_r        <= '0;
      inertia_row_x_r <= '0;
      inertia_row_y_r <= '0;
      inertia_row_z_r <= '0;
      known_torque_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAIN_K:       gain_k_r        <= cfg_data[31:0];
        CFG_GAIN_P:       gain_p_r        <= cfg_data[31:0];
        CFG_INERTIA_X:    inertia_row_x_r <= cfg_data;
        CFG_INERTIA_Y:    inertia_row_y_r <= cfg_data;
        CFG_INERTIA_Z:    inertia_row_z_r <= cfg_data;
        CFG_KNOWN_TORQUE: known_torque_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      inertia[0][j] = field21(inertia_row_x_r, j);
      inertia[1][j] = field21(inertia_row_y_r, j);
      inertia[2][j] = field21(inertia_row_z_r, j);
    end
  end

  always_comb begin
    in_sig[0]  = in_sigma_x;     in_sig[1]  = in_sigma_y;     in_sig[2]  = in_sigma_z;
    in_rerr[0] = in_rate_err_x;  in_rerr[1] = in_rate_err_y;  in_rerr[2] = in_rate_err_z;
    in_wr[0]   = in_ref_rate_x;  in_wr[1]   = in_ref_rate_y;  in_wr[2]   = in_ref_rate_z;
    in_dwr[0]  = in_ref_accel_x; in_dwr[1]  = in_ref_accel_y; in_dwr[2]  = in_ref_accel_z;
  end

  // stage 1: omega = rate error + reference rate, saturated
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      w_r[i]     <= sat32(wide_t'(in_rerr[i]) + wide_t'(in_wr[i]));
      wr1_r[i]   <= in_wr[i];
      dwr1_r[i]  <= in_dwr[i];
      sig1_r[i]  <= in_sig[i];
      rerr1_r[i] <= in_rerr[i];
    end
  end

  // gains are unsigned, so the products take a zero sign bit
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kprod[i] = GP_W'($signed({1'b0, gain_k_r})) * GP_W'(sig1_r[i])
                 + (GP_W'(1) <<< (FRAC_BITS - 1));
      pprod[i] = GP_W'($signed({1'b0, gain_p_r})) * GP_W'(rerr1_r[i])
                 + (GP_W'(1) <<< (FRAC_BITS - 1));
    end
  end

  // stage 2: rounded gain terms
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      kterm_r[i] <= kprod[i][GP_W-1:FRAC_BITS];
      pterm_r[i] <= pprod[i][GP_W-1:FRAC_BITS];
      wr2_r[i]   <= wr1_r[i];
      dwr2_r[i]  <= dwr1_r[i];
    end
  end

  // stages 2-3: I*omega and omega x ref_rate
  mrp_matvec u_mv_iw (
    .clk (clk),
    .m   (inertia),
    .v   (w_r),
    .r   (iw)
  );

  mrp_cross #(.FRAC_BITS(FRAC_BITS)) u_cr_wxr (
    .clk (clk),
    .a   (w_r),
    .b   (wr1_r),
    .r   (wxr)
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      gsum3_r[i] <= GS_W'(kterm_r[i]) + GS_W'(pterm_r[i]);
      wr3_r[i]   <= wr2_r[i];
      dwr3_r[i]  <= dwr2_r[i];
    end
  end

  // stage 4: ref_accel - omega x ref_rate
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d_r[i]     <= sat32(wide_t'(dwr3_r[i]) - wide_t'(wxr[i]));
      iw4_r[i]   <= iw[i];
      wr4_r[i]   <= wr3_r[i];
      gsum4_r[i] <= gsum3_r[i];
    end
  end

  // stages 5-6: I*d and ref_rate x (I*omega)
  mrp_matvec u_mv_id (
    .clk (clk),
    .m   (inertia),
    .v   (d_r),
    .r   (t4)
  );

  mrp_cross #(.FRAC_BITS(FRAC_BITS)) u_cr_t3 (
    .clk (clk),
    .a   (wr4_r),
    .b   (iw4_r),
    .r   (t3)
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      gsum5_r[i] <= gsum4_r[i];
      gsum6_r[i] <= gsum5_r[i];
    end
  end

  // known torque rescaled from its own fraction width
  generate
    if (FRAC_BITS >= TORQUE_FRAC) begin : g_lt_up
      localparam int LSH = FRAC_BITS - TORQUE_FRAC;
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          lt[i] = wide_t'(field21(known_torque_r, i)) <<< LSH;
        end
      end
    end else begin : g_lt_dn
      localparam int RSH = TORQUE_FRAC - FRAC_BITS;
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          lt[i] = (wide_t'(field21(known_torque_r, i)) + (wide_t'(1) <<< (RSH - 1)))
                  >>> RSH;
        end
      end
    end
  endgenerate

  // stage 7: torque = -(gains - t3 - t4 + known), saturated
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      tq_r[i] <= sat32(wide_t'(t3[i]) + wide_t'(t4[i]) - wide_t'(gsum6_r[i]) - lt[i]);
    end
  end

  assign out_valid    = vld_r[PIPE_LAT-1];
  assign out_torque_x = tq_r[0];
  assign out_torque_y = tq_r[1];
  assign out_torque_z = tq_r[2];

  // every result traces back to a transfer exactly one latency earlier
  `MRP_ASSERT_IMP(a_out_lat, out_valid, $past(in_acc, PIPE_LAT), "result without matching transfer")
  // the block takes samples every cycle once out of reset
  `MRP_ASSERT_NXT(a_busy_free, rst_n, !busy, "busy held after reset release")

endmodule

[rtl/mrp_matvec.sv]
module mrp_matvec (
  input  logic          clk,
  input  mrp_pkg::mat3_t m,
  input  mrp_pkg::vec3_t v,
  output mrp_pkg::vec3_t r
);
  import mrp_pkg::*;

  localparam int PW = FIELD_W + 32;
  localparam int RW = PW - INERTIA_FRAC;

  logic signed [PW-1:0] prod [3][3];
  logic signed [RW-1:0] term_r [3][3];
  q_t                   sum_r [3];

  // round half up of each product, one multiplier per element
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] = PW'(m[i][j]) * PW'(v[j])
                     + (PW'(1) <<< (INERTIA_FRAC - 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        term_r[i][j] <= prod[i][j][PW-1:INERTIA_FRAC];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sum_r[i] <= sat32(wide_t'(term_r[i][0]) + wide_t'(term_r[i][1])
                        + wide_t'(term_r[i][2]));
    end
  end

  assign r = sum_r;

endmodule

[rtl/mrp_cross.sv]
module mrp_cross #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  mrp_pkg::vec3_t a,
  input  mrp_pkg::vec3_t b,
  output mrp_pkg::vec3_t r
);
  import mrp_pkg::*;

  localparam int PW = 65;
  localparam int RW = PW - FRAC_BITS;

  logic signed [PW-1:0] prod [6];
  logic signed [RW-1:0] term_r [6];
  q_t                   res_r [3];

  // terms in minuend/subtrahend pairs per component
  always_comb begin
    prod[0] = PW'(a[1]) * PW'(b[2]);
    prod[1] = PW'(a[2]) * PW'(b[1]);
    prod[2] = PW'(a[2]) * PW'(b[0]);
    prod[3] = PW'(a[0]) * PW'(b[2]);
    prod[4] = PW'(a[0]) * PW'(b[1]);
    prod[5] = PW'(a[1]) * PW'(b[0]);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      term_r[k] <= RW'((prod[k] + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      res_r[i] <= sat32(wide_t'(term_r[2*i]) - wide_t'(term_r[2*i+1]));
    end
  end

  assign r = res_r;

endmodule

[dv/mrp_pd_attitude_torque_tb_pkg.sv]
package mrp_pd_attitude_torque_tb_pkg;
  import mrp_pkg::*;

  typedef longint lvec_t [3];

  typedef struct {
    q_t sigma [3];
    q_t rate_err [3];
    q_t ref_rate [3];
    q_t ref_accel [3];
  } sample_t;

  typedef struct {
    q_t t [3];
  } torque_t;

  class torque_checker;
    int              frac;
    int              errors;
    logic [31:0]     gain_k;
    logic [31:0]     gain_p;
    pack63_t         row_x;
    pack63_t         row_y;
    pack63_t         row_z;
    pack63_t         known_torque;
    longint          inertia [3][3];
    torque_t         expected_torque [$];

    function new(int frac_bits);
      frac         = frac_bits;
      errors       = 0;
      gain_k       = '0;
      gain_p       = '0;
      row_x        = '0;
      row_y        = '0;
      row_z        = '0;
      known_torque = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, pack63_t data);
      case (idx)
        CFG_GAIN_K:       gain_k = data[31:0];
        CFG_GAIN_P:       gain_p = data[31:0];
        CFG_INERTIA_X:    row_x = data;
        CFG_INERTIA_Y:    row_y = data;
        CFG_INERTIA_Z:    row_z = data;
        CFG_KNOWN_TORQUE: known_torque = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_torque.size();
    endfunction

    // floor of (x + half lsb) / 2^s
    function longint round_half_up(longint x, int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clamp32(longint x);
      if (x > longint'(32'sh7fffffff)) return longint'(32'sh7fffffff);
      if (x < longint'(32'sh80000000)) return longint'(32'sh80000000);
      return x;
    endfunction

    function longint elem_of(pack63_t r, int j);
      fld_t f;
      f = r[j*FIELD_W +: FIELD_W];
      return longint'(f);
    endfunction

    function void inertia_times(input lvec_t v, output lvec_t r);
      longint acc;
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          acc += round_half_up(inertia[i][j] * v[j], INERTIA_FRAC);
        end
        r[i] = clamp32(acc);
      end
    endfunction

    function void cross3(input lvec_t a, input lvec_t b, output lvec_t r);
      r[0] = clamp32(round_half_up(a[1] * b[2], frac) - round_half_up(a[2] * b[1], frac));
      r[1] = clamp32(round_half_up(a[2] * b[0], frac) - round_half_up(a[0] * b[2], frac));
      r[2] = clamp32(round_half_up(a[0] * b[1], frac) - round_half_up(a[1] * b[0], frac));
    endfunction

    function void note_sample(sample_t s);
      lvec_t   sig, rerr, wr, dwr, w, iw, t3, wxr, d, t4;
      longint  kk, pp, lk, lt, lr, sat;
      torque_t res;
      kk = longint'(gain_k);
      pp = longint'(gain_p);
      for (int j = 0; j < 3; j++) begin
        inertia[0][j] = elem_of(row_x, j);
        inertia[1][j] = elem_of(row_y, j);
        inertia[2][j] = elem_of(row_z, j);
      end
      for (int i = 0; i < 3; i++) begin
        sig[i]  = longint'(s.sigma[i]);
        rerr[i] = longint'(s.rate_err[i]);
        wr[i]   = longint'(s.ref_rate[i]);
        dwr[i]  = longint'(s.ref_accel[i]);
        w[i]    = clamp32(rerr[i] + wr[i]);
      end
      inertia_times(w, iw);
      cross3(wr, iw, t3);
      cross3(w, wr, wxr);
      for (int i = 0; i < 3; i++) begin
        d[i] = clamp32(dwr[i] - wxr[i]);
      end
      inertia_times(d, t4);
      for (int i = 0; i < 3; i++) begin
        lk = elem_of(known_torque, i);
        if (frac >= TORQUE_FRAC) begin
          lt = lk <<< (frac - TORQUE_FRAC);
        end else begin
          lt = round_half_up(lk, TORQUE_FRAC - frac);
        end
        lr = round_half_up(kk * sig[i], frac) + round_half_up(pp * rerr[i], frac)
             - t3[i] - t4[i] + lt;
        sat = clamp32(-lr);
        res.t[i] = sat[31:0];
      end
      expected_torque.push_back(res);
    endfunction

    function void check_torque(q_t tx, q_t ty, q_t tz);
      torque_t exp_t;
      q_t      act [3];
      string   axis [3];
      act  = '{tx, ty, tz};
      axis = '{"x", "y", "z"};
      if (expected_torque.size() == 0) begin
        $display("%0t torque with nothing expected: x %0d y %0d z %0d", $time, tx, ty, tz);
        errors++;
        return;
      end
      exp_t = expected_torque.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (act[i] !== exp_t.t[i]) begin
          $display("%0t torque_%s mismatch: expected %0d actual %0d",
                   $time, axis[i], exp_t.t[i], act[i]);
          errors++;
        end
      end
    endfunction
  endclass

endpackage

[dv/tb_mrp_pd_attitude_torque.sv]
module tb_mrp_pd_attitude_torque;
  timeunit 1ns;
  timeprecision 1ps;

  import mrp_pkg::*;
  import mrp_pd_attitude_torque_tb_pkg::*;

  localparam int FRAC_BITS      = 16;
  localparam int RAND_PER_PHASE = 119;
  localparam int MAX_GAP        = 24;
  localparam q_t Q_POS          = 32'sh7fffffff;
  localparam q_t Q_NEG          = 32'sh80000000;
  localparam fld_t FLD_POS      = 21'sh0fffff;
  localparam fld_t FLD_NEG      = 21'sh100000;

  // register settings the run steps through
  typedef enum int {
    SET_DIRECTED,
    SET_ZERO,
    SET_TYPICAL,
    SET_POS_MAX,
    SET_NEG_MAX,
    SET_RANDOM
  } setting_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  pack63_t cfg_data = '0;
  logic    start = 1'b0;
  logic    busy;
  q_t      in_sigma_x = '0, in_sigma_y = '0, in_sigma_z = '0;
  q_t      in_rate_err_x = '0, in_rate_err_y = '0, in_rate_err_z = '0;
  q_t      in_ref_rate_x = '0, in_ref_rate_y = '0, in_ref_rate_z = '0;
  q_t      in_ref_accel_x = '0, in_ref_accel_y = '0, in_ref_accel_z = '0;
  logic    out_valid;
  q_t      out_torque_x, out_torque_y, out_torque_z;

  torque_checker torque_chk;
  sample_t       seen_sample;

  mrp_pd_attitude_torque #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .in_sigma_x     (in_sigma_x),
    .in_sigma_y     (in_sigma_y),
    .in_sigma_z     (in_sigma_z),
    .in_rate_err_x  (in_rate_err_x),
    .in_rate_err_y  (in_rate_err_y),
    .in_rate_err_z  (in_rate_err_z),
    .in_ref_rate_x  (in_ref_rate_x),
    .in_ref_rate_y  (in_ref_rate_y),
    .in_ref_rate_z  (in_ref_rate_z),
    .in_ref_accel_x (in_ref_accel_x),
    .in_ref_accel_y (in_ref_accel_y),
    .in_ref_accel_z (in_ref_accel_z),
    .out_valid      (out_valid),
    .out_torque_x   (out_torque_x),
    .out_torque_y   (out_torque_y),
    .out_torque_z   (out_torque_z)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // input transfer: start high and busy low at the edge, values seen before the edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      seen_sample.sigma     = '{in_sigma_x, in_sigma_y, in_sigma_z};
      seen_sample.rate_err  = '{in_rate_err_x, in_rate_err_y, in_rate_err_z};
      seen_sample.ref_rate  = '{in_ref_rate_x, in_ref_rate_y, in_ref_rate_z};
      seen_sample.ref_accel = '{in_ref_accel_x, in_ref_accel_y, in_ref_accel_z};
      torque_chk.note_sample(seen_sample);
    end
  end

  // result transfer: one cycle strobe, no back pressure possible
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      torque_chk.check_torque(out_torque_x, out_torque_y, out_torque_z);
    end
  end

  // register write, takes effect at the next edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input pack63_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    torque_chk.set_reg(idx, data);
    @(posedge clk);
  endtask

  function automatic pack63_t pack3(fld_t e0, fld_t e1, fld_t e2);
    return {e2, e1, e0};
  endfunction

  function automatic fld_t small_fld(int span);
    return fld_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic pack63_t rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[62:0];
  endfunction

  // writes all six registers, then one index past the map that must be dropped
  task automatic apply_setting(input setting_t kind);
    logic [CFG_IDX_W-1:0] spare;
    spare = CFG_IDX_W'($urandom_range(int'(CFG_KNOWN_TORQUE) + 1, 2**CFG_IDX_W - 1));
    case (kind)
      SET_DIRECTED: begin
        // gain_k of one half makes half-lsb rounding visible
        write_reg(CFG_GAIN_K, pack63_t'(32'h0000_8000));
        write_reg(CFG_GAIN_P, pack63_t'(32'hffff_ffff));
        write_reg(CFG_INERTIA_X, pack3(FLD_POS, FLD_NEG, 21'sd1));
        write_reg(CFG_INERTIA_Y, pack3(FLD_NEG, FLD_POS, -21'sd1));
        write_reg(CFG_INERTIA_Z, pack3(21'sd0, FLD_POS, FLD_NEG));
        write_reg(CFG_KNOWN_TORQUE, pack3(FLD_POS, FLD_NEG, -21'sd1));
      end
      SET_ZERO: begin
        write_reg(CFG_GAIN_K, '0);
        write_reg(CFG_GAIN_P, '0);
        write_reg(CFG_INERTIA_X, '0);
        write_reg(CFG_INERTIA_Y, '0);
        write_reg(CFG_INERTIA_Z, '0);
        write_reg(CFG_KNOWN_TORQUE, '0);
      end
      SET_TYPICAL: begin
        // positive diagonal inertia, small coupling terms
        write_reg(CFG_GAIN_K, pack63_t'($urandom_range(0, 1 << 20)));
        write_reg(CFG_GAIN_P, pack63_t'($urandom_range(0, 1 << 20)));
        write_reg(CFG_INERTIA_X, pack3(fld_t'($urandom_range(256, 1 << 19)),
                                       small_fld(1024), small_fld(1024)));
        write_reg(CFG_INERTIA_Y, pack3(small_fld(1024),
                                       fld_t'($urandom_range(256, 1 << 19)), small_fld(1024)));
        write_reg(CFG_INERTIA_Z, pack3(small_fld(1024), small_fld(1024),
                                       fld_t'($urandom_range(256, 1 << 19))));
        write_reg(CFG_KNOWN_TORQUE, pack3(small_fld(1 << 16), small_fld(1 << 16),
                                          small_fld(1 << 16)));
      end
      SET_POS_MAX: begin
        write_reg(CFG_GAIN_K, pack63_t'(32'hffff_ffff));
        write_reg(CFG_GAIN_P, pack63_t'(32'hffff_ffff));
        write_reg(CFG_INERTIA_X, pack3(FLD_POS, FLD_POS, FLD_POS));
        write_reg(CFG_INERTIA_Y, pack3(FLD_POS, FLD_POS, FLD_POS));
        write_reg(CFG_INERTIA_Z, pack3(FLD_POS, FLD_POS, FLD_POS));
        write_reg(CFG_KNOWN_TORQUE, pack3(FLD_POS, FLD_POS, FLD_POS));
      end
      SET_NEG_MAX: begin
        write_reg(CFG_GAIN_K, pack63_t'(32'hffff_ffff));
        write_reg(CFG_GAIN_P, pack63_t'(32'h0000_0001));
        write_reg(CFG_INERTIA_X, pack3(FLD_NEG, FLD_NEG, FLD_NEG));
        write_reg(CFG_INERTIA_Y, pack3(FLD_NEG, FLD_NEG, FLD_NEG));
        write_reg(CFG_INERTIA_Z, pack3(FLD_NEG, FLD_NEG, FLD_NEG));
        write_reg(CFG_KNOWN_TORQUE, pack3(FLD_NEG, FLD_NEG, FLD_NEG));
      end
      default: begin
        // full-width random, upper data bits of the gain writes too
        write_reg(CFG_GAIN_K, rand63());
        write_reg(CFG_GAIN_P, rand63());
        write_reg(CFG_INERTIA_X, rand63());
        write_reg(CFG_INERTIA_Y, rand63());
        write_reg(CFG_INERTIA_Z, rand63());
        write_reg(CFG_KNOWN_TORQUE, rand63());
      end
    endcase
    write_reg(spare, rand63());
    cfg_we <= 1'b0;
  endtask

  // idle gap before the next transfer, geometric with a cap
  function automatic int draw_gap(int idle_pct);
    int g;
    g = 0;
    while (g < MAX_GAP && $urandom_range(0, 99) < idle_pct) g++;
    return g;
  endfunction

  // mostly moderate values, with extremes and full-width noise mixed in
  function automatic q_t rand_q();
    case ($urandom_range(0, 15))
      0:       return Q_POS;
      1:       return Q_NEG;
      2:       return '0;
      3:       return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      4, 5, 6, 7, 8, 9: return q_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      default: return q_t'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    for (int i = 0; i < 3; i++) begin
      s.sigma[i]     = rand_q();
      s.rate_err[i]  = rand_q();
      s.ref_rate[i]  = rand_q();
      s.ref_accel[i] = rand_q();
    end
    return s;
  endfunction

  function automatic sample_t even_sample(q_t sg, q_t re, q_t rr, q_t ra);
    sample_t s;
    s.sigma     = '{sg, sg, sg};
    s.rate_err  = '{re, re, re};
    s.ref_rate  = '{rr, rr, rr};
    s.ref_accel = '{ra, ra, ra};
    return s;
  endfunction

  // start stays high across back-to-back transfers, lowered only for a gap
  task automatic send_sample(input sample_t s, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_sigma_x     <= s.sigma[0];
    in_sigma_y     <= s.sigma[1];
    in_sigma_z     <= s.sigma[2];
    in_rate_err_x  <= s.rate_err[0];
    in_rate_err_y  <= s.rate_err[1];
    in_rate_err_z  <= s.rate_err[2];
    in_ref_rate_x  <= s.ref_rate[0];
    in_ref_rate_y  <= s.ref_rate[1];
    in_ref_rate_z  <= s.ref_rate[2];
    in_ref_accel_x <= s.ref_accel[0];
    in_ref_accel_y <= s.ref_accel[1];
    in_ref_accel_z <= s.ref_accel[2];
    do @(posedge clk); while (busy);
  endtask

  task automatic send_directed(input int idle_pct);
    sample_t s;
    send_sample(even_sample('0, '0, '0, '0), draw_gap(idle_pct));
    send_sample(even_sample(Q_POS, Q_POS, Q_POS, Q_POS), draw_gap(idle_pct));
    send_sample(even_sample(Q_NEG, Q_NEG, Q_NEG, Q_NEG), draw_gap(idle_pct));
    // half an lsb on the gain product, rounds up on both signs
    send_sample(even_sample(32'sd1, '0, '0, '0), draw_gap(idle_pct));
    send_sample(even_sample(-32'sd1, '0, '0, '0), draw_gap(idle_pct));
    send_sample(even_sample(Q_POS, '0, '0, '0), draw_gap(idle_pct));
    // body rate sum saturates high, then low
    send_sample(even_sample('0, Q_POS, Q_POS, '0), draw_gap(idle_pct));
    send_sample(even_sample('0, Q_NEG, Q_NEG, '0), draw_gap(idle_pct));
    // rate and reference cancel, body rate zero
    send_sample(even_sample('0, 32'sd123456, -32'sd123456, 32'sd65536), draw_gap(idle_pct));
    send_sample(even_sample('0, '0, Q_POS, '0), draw_gap(idle_pct));
    send_sample(even_sample(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa),
                draw_gap(idle_pct));
    send_sample(even_sample(32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555),
                draw_gap(idle_pct));
    // acceleration minus the rate cross term saturates
    s.sigma     = '{'0, '0, '0};
    s.rate_err  = '{Q_POS, Q_NEG, Q_POS};
    s.ref_rate  = '{Q_NEG, Q_POS, 32'sd65536};
    s.ref_accel = '{Q_NEG, Q_POS, Q_NEG};
    send_sample(s, draw_gap(idle_pct));
    // every component different, mixed extremes
    s.sigma     = '{Q_POS, Q_NEG, '0};
    s.rate_err  = '{32'sd1, -32'sd1, Q_POS};
    s.ref_rate  = '{Q_NEG, '0, 32'sd1};
    s.ref_accel = '{'0, Q_POS, -32'sd1};
    send_sample(s, draw_gap(idle_pct));
    // a realistic slew sample
    s.sigma     = '{32'sd6554, -32'sd3277, 32'sd1311};
    s.rate_err  = '{32'sd655, 32'sd1310, -32'sd327};
    s.ref_rate  = '{32'sd65, -32'sd131, 32'sd33};
    s.ref_accel = '{32'sd7, 32'sd0, -32'sd13};
    send_sample(s, draw_gap(idle_pct));
  endtask

  // wait one edge so the input monitor has run, then until all torques are back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (torque_chk.pending() != 0);
  endtask

  initial begin
    setting_t schedule [8];
    int       idle_pcts [3];
    schedule  = '{SET_DIRECTED, SET_TYPICAL, SET_POS_MAX, SET_RANDOM,
                  SET_NEG_MAX, SET_ZERO, SET_TYPICAL, SET_RANDOM};
    // no idling, heavy sender idling, light sender idling
    idle_pcts = '{0, 73, 28};
    torque_chk = new(FRAC_BITS);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 8; ph++) begin
      apply_setting(schedule[ph]);
      if (schedule[ph] == SET_DIRECTED) begin
        send_directed(idle_pcts[ph % 3]);
      end
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        send_sample(random_sample(), draw_gap(idle_pcts[ph % 3]));
      end
      drain();
      // pipeline tail before the next register writes
      repeat (PIPE_LAT) @(posedge clk);
    end

    repeat (2 * PIPE_LAT) @(posedge clk);
    if (torque_chk.errors == 0 && torque_chk.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
